// ----- rtl/lhb_pkg.sv -----
// Shared types and constants for the LLR histogram binning block.
package lhb_pkg;

   // Histogram geometry
   localparam int NUM_BINS    = 4096;
   localparam int BIN_WIDTH   = $clog2(NUM_BINS);
   localparam int ADDR_WIDTH  = BIN_WIDTH + 1;
   localparam int COUNT_WIDTH = 32;

   // Field widths
   localparam int LLR_WIDTH   = 16;
   localparam int SHIFT_WIDTH = 4;
   localparam int CSR_IDX_WIDTH = 2;

   // Command codes
   localparam logic [1:0] CMD_ACCUMULATE = 2'd0;
   localparam logic [1:0] CMD_READ       = 2'd1;
   localparam logic [1:0] CMD_CLEAR      = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LLR_LOW   = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LLR_HIGH  = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BIN_SHIFT = 2'd2;

   // Configuration reset values
   localparam logic signed [LLR_WIDTH-1:0] LLR_LOW_RESET   = -16'sd16000;
   localparam logic signed [LLR_WIDTH-1:0] LLR_HIGH_RESET  = 16'sd16000;
   localparam logic [SHIFT_WIDTH-1:0]      BIN_SHIFT_RESET = 4'd3;

   typedef struct packed {
      logic [1:0]                  command;
      logic                        data_bit;
      logic signed [LLR_WIDTH-1:0] llr;
      logic [11:0]                 read_bin;
   } req_type;

   typedef struct packed {
      logic [31:0] count;
      logic [11:0] bin;
   } rsp_type;

   typedef struct packed {
      logic signed [LLR_WIDTH-1:0] llr_low;
      logic signed [LLR_WIDTH-1:0] llr_high;
      logic [SHIFT_WIDTH-1:0]      bin_shift;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOCATE,
      ST_UPDATE,
      ST_CLEAR
   } state_type;

endpackage

// ----- rtl/lhb_count_ram.sv -----
// Simple dual-port count memory: one write port, one registered read port.
module lhb_count_ram #(
   parameter int AddrWidth = 13,
   parameter int DataWidth = 32
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [DataWidth-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [DataWidth-1:0] rd_data
);

   logic [DataWidth-1:0] mem_ff [2**AddrWidth];
   logic [DataWidth-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered output
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/lhb_bin_locate.sv -----
// Clips a soft value to the configured limits and maps it to its nearest bin.
module lhb_bin_locate (
   input  lhb_pkg::cfg_type                      cfg,
   input  logic signed [lhb_pkg::LLR_WIDTH-1:0]  llr,
   output logic [lhb_pkg::BIN_WIDTH-1:0]         bin
);

   logic signed [lhb_pkg::LLR_WIDTH-1:0] clip_high;
   logic signed [lhb_pkg::LLR_WIDTH-1:0] clipped;
   logic signed [lhb_pkg::LLR_WIDTH:0]   diff;
   logic [lhb_pkg::LLR_WIDTH:0]          offset;
   logic [lhb_pkg::LLR_WIDTH:0]          half;
   logic [lhb_pkg::LLR_WIDTH+1:0]        rounded;
   logic [lhb_pkg::LLR_WIDTH+1:0]        idx;

   // Upper limit first, then lower limit (lower wins if limits cross)
   always_comb begin
      clip_high = (llr > cfg.llr_high) ? cfg.llr_high : llr;
      clipped   = (clip_high < cfg.llr_low) ? cfg.llr_low : clip_high;
   end

   // Offset from the left edge, rounded to nearest bin
   always_comb begin
      diff    = (lhb_pkg::LLR_WIDTH+1)'(clipped) - (lhb_pkg::LLR_WIDTH+1)'(cfg.llr_low);
      offset  = diff;  // never negative after clipping
      half    = ((lhb_pkg::LLR_WIDTH+1)'(1) << cfg.bin_shift) >> 1;
      rounded = (lhb_pkg::LLR_WIDTH+2)'(offset) + (lhb_pkg::LLR_WIDTH+2)'(half);
      idx     = rounded >> cfg.bin_shift;
   end

   // Saturate at the top bin
   assign bin = (idx > (lhb_pkg::LLR_WIDTH+2)'(lhb_pkg::NUM_BINS - 1))
              ? lhb_pkg::BIN_WIDTH'(lhb_pkg::NUM_BINS - 1)
              : lhb_pkg::BIN_WIDTH'(idx);

endmodule

// ----- rtl/llr_histogram_binning.sv -----
// Top level: two LLR histograms held in one count memory, with command FSM.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-----------------------------------
//  request  | start, busy             | req_item  (command, bit, llr, bin)
//  response | rsp_strobe (1 cycle)    | rsp_item  (count, bin)
//  config   | csr_valid, csr_ready    | csr_index, csr_data
//
// Accumulate and read pass through three steps each (accept, bin locate and memory
// read, read-modify-write); the response strobes in the cycle after the update,
// while the next item may already be accepted. The registered read port of the
// count memory and the return to idle mean that no item overlaps another one's
// update.
// Clear sweeps all 2*NUM_BINS entries at one per cycle, then
// responds. After reset the same sweep runs with busy high and no response.
// Configuration writes are taken at any time; the response side cannot stall.
module llr_histogram_binning (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  lhb_pkg::req_type                         req_item,
   output logic                                     rsp_strobe,
   output lhb_pkg::rsp_type                         rsp_item,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [lhb_pkg::CSR_IDX_WIDTH-1:0]        csr_index,
   input  logic [lhb_pkg::LLR_WIDTH-1:0]            csr_data
);

   lhb_pkg::state_type                state_ff, state_in;
   lhb_pkg::req_type                  req_ff, req_in;
   lhb_pkg::cfg_type                  cfg_ff;
   lhb_pkg::rsp_type                  rsp_ff, rsp_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [lhb_pkg::ADDR_WIDTH-1:0]    addr_ff, addr_in;
   logic [lhb_pkg::ADDR_WIDTH-1:0]    clr_ptr_ff, clr_ptr_in;
   logic                              reply_ff, reply_in;

   logic [lhb_pkg::BIN_WIDTH-1:0]     loc_bin;
   logic                              mem_wr_en;
   logic [lhb_pkg::ADDR_WIDTH-1:0]    mem_wr_addr;
   logic [lhb_pkg::COUNT_WIDTH-1:0]   mem_wr_data;
   logic                              mem_rd_en;
   logic [lhb_pkg::ADDR_WIDTH-1:0]    mem_rd_addr;
   logic [lhb_pkg::COUNT_WIDTH-1:0]   mem_rd_data;
   logic [lhb_pkg::COUNT_WIDTH-1:0]   cnt_inc;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.llr_low   <= lhb_pkg::LLR_LOW_RESET;
         cfg_ff.llr_high  <= lhb_pkg::LLR_HIGH_RESET;
         cfg_ff.bin_shift <= lhb_pkg::BIN_SHIFT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lhb_pkg::CSR_LLR_LOW:   cfg_ff.llr_low   <= csr_data;
            lhb_pkg::CSR_LLR_HIGH:  cfg_ff.llr_high  <= csr_data;
            lhb_pkg::CSR_BIN_SHIFT: cfg_ff.bin_shift <= csr_data[lhb_pkg::SHIFT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Bin computation from the captured item
   lhb_bin_locate u_locate (
      .cfg (cfg_ff),
      .llr (req_ff.llr),
      .bin (loc_bin)
   );

   // Count memory
   lhb_count_ram #(
      .AddrWidth (lhb_pkg::ADDR_WIDTH),
      .DataWidth (lhb_pkg::COUNT_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Saturating increment
   assign cnt_inc = (mem_rd_data == '1) ? mem_rd_data : mem_rd_data + 1'b1;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lhb_pkg::ST_CLEAR;
         clr_ptr_ff   <= '0;
         reply_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         reply_ff     <= reply_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      addr_ff <= addr_in;
      rsp_ff  <= rsp_in;
   end

   // Next state and memory control
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      addr_in      = addr_ff;
      clr_ptr_in   = clr_ptr_ff;
      reply_in     = reply_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = addr_ff;
      mem_wr_data  = cnt_inc;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = addr_ff;
      case (state_ff)
         lhb_pkg::ST_IDLE: begin
            if (start) begin
               req_in = req_item;
               if (req_item.command == lhb_pkg::CMD_CLEAR) begin
                  state_in   = lhb_pkg::ST_CLEAR;
                  clr_ptr_in = '0;
                  reply_in   = 1'b1;
               end else begin
                  state_in = lhb_pkg::ST_LOCATE;
               end
            end
         end
         lhb_pkg::ST_LOCATE: begin
            if (req_ff.command == lhb_pkg::CMD_ACCUMULATE) begin
               addr_in = {req_ff.data_bit, loc_bin};
            end else begin
               addr_in = {req_ff.data_bit, lhb_pkg::BIN_WIDTH'(req_ff.read_bin)};
            end
            mem_rd_en   = 1'b1;
            mem_rd_addr = addr_in;
            state_in    = lhb_pkg::ST_UPDATE;
         end
         lhb_pkg::ST_UPDATE: begin
            state_in     = lhb_pkg::ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            case (req_ff.command)
               lhb_pkg::CMD_ACCUMULATE: begin
                  mem_wr_en    = 1'b1;
                  rsp_in.count = 32'(cnt_inc);
                  rsp_in.bin   = 12'(addr_ff[lhb_pkg::BIN_WIDTH-1:0]);
               end
               lhb_pkg::CMD_READ: begin
                  rsp_in.bin = req_ff.read_bin;
                  if (int'(req_ff.read_bin) < lhb_pkg::NUM_BINS) begin
                     rsp_in.count = 32'(mem_rd_data);
                  end
               end
               default: ;
            endcase
         end
         lhb_pkg::ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ptr_ff;
            mem_wr_data = '0;
            clr_ptr_in  = clr_ptr_ff + 1'b1;
            if (clr_ptr_ff == '1) begin
               state_in     = lhb_pkg::ST_IDLE;
               reply_in     = 1'b0;
               rsp_valid_in = reply_ff;
               rsp_in       = '0;
            end
         end
         default: state_in = lhb_pkg::ST_IDLE;
      endcase
   end

   assign busy       = (state_ff != lhb_pkg::ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   // A response only follows an update or the end of a clear sweep
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == lhb_pkg::ST_UPDATE ||
                      $past(state_ff) == lhb_pkg::ST_CLEAR))
      else $error("response without a finished command");

   // Memory is written only by an update or by the clear sweep
   a_wr_state: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == lhb_pkg::ST_UPDATE || state_ff == lhb_pkg::ST_CLEAR))
      else $error("count memory written outside update or clear");

   // An accepted item always makes the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not start work");

   // An update always follows the memory read of its item
   a_read_before_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lhb_pkg::ST_UPDATE) |-> ($past(state_ff) == lhb_pkg::ST_LOCATE))
      else $error("update without a preceding memory read");

endmodule
